/* sv/pvr_pkg.sv */
// ----------------------------------------------------------------------------
// pvr_pkg: shared widths, types and helpers for the plane velocity rescaler
// Fixed-point widths derive from VEL_W and NRM_W; squared-length threshold
// and the square-root digit step live here.
// ----------------------------------------------------------------------------
package pvr_pkg;

  localparam int VEL_W  = 32;               // Q16.16 velocity and speed
  localparam int NRM_W  = 16;               // Q2.14 normal and scales
  localparam int FRAC_N = 14;               // fraction bits of Q2.14
  localparam int SQ_W   = 2 * VEL_W;        // squared length, Q32.32
  localparam logic [SQ_W-1:0] THRESH_SQ = SQ_W'(429497);

  localparam int DOT_W  = VEL_W + NRM_W + 1;   // sum of three products
  localparam int D16_W  = DOT_W - FRAC_N;      // dot rounded to 16 frac bits
  localparam int P_W    = D16_W + NRM_W;       // projection component
  localparam int PARA_W = P_W + 1;             // in-plane component
  localparam int PA_W   = P_W + NRM_W;
  localparam int PB_W   = PARA_W + NRM_W;
  localparam int ACC_W  = PB_W + 1;
  localparam int ACC_SH = 2 * FRAC_N;
  localparam int NVR_W  = ACC_W - ACC_SH;      // rounded, before saturation

  localparam int RAD_SH = 30;                  // radicand = S << 30
  localparam int ROOT_W = (SQ_W + RAD_SH) / 2; // root bits
  localparam int REM_W  = ROOT_W + 3;
  localparam int LO_W   = ROOT_W / 2;
  localparam int HI_W   = ROOT_W - LO_W;
  localparam int NUM_W  = VEL_W + ROOT_W;      // |speed| * Lnew + Lold/2
  localparam int QUO_W  = VEL_W;

  typedef logic signed [VEL_W-1:0] vel_t;
  typedef logic signed [NRM_W-1:0] nrm_t;

  typedef struct packed {
    nrm_t normal_x;
    nrm_t normal_y;
    nrm_t normal_z;
    nrm_t perp_scale;
    nrm_t para_scale;
    vel_t vel_x;
    vel_t vel_y;
    vel_t vel_z;
    vel_t speed_in;
  } in_t;

  typedef struct packed {
    vel_t vx;
    vel_t vy;
    vel_t vz;
    vel_t spd;
    logic moving;
    logic stopped;
  } side_t;

  typedef struct packed {
    vel_t new_vel_x;
    vel_t new_vel_y;
    vel_t new_vel_z;
    vel_t speed_out;
    logic was_moving;
  } res_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  // One digit of restoring square root: bring in two radicand bits.
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [1:0] pair);
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] t;
    sqrt_st_t o;
    r2 = {s.rem[REM_W-3:0], pair};
    t  = {1'b0, s.root, 2'b01};
    if (r2 >= t) begin
      o.rem  = r2 - t;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

/* sv/pvr_if.sv */
// ----------------------------------------------------------------------------
// pvr_if: request and result channels of the plane velocity rescaler
// Valid/ready handshake with the payload fields of one item.
// ----------------------------------------------------------------------------
interface pvr_in_if import pvr_pkg::*; ();
  logic valid;
  logic ready;
  nrm_t normal_x;
  nrm_t normal_y;
  nrm_t normal_z;
  nrm_t perp_scale;
  nrm_t para_scale;
  vel_t vel_x;
  vel_t vel_y;
  vel_t vel_z;
  vel_t speed_in;

  modport source (output valid, normal_x, normal_y, normal_z, perp_scale, para_scale,
                  vel_x, vel_y, vel_z, speed_in, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, perp_scale, para_scale,
                  vel_x, vel_y, vel_z, speed_in, output ready);
endinterface

interface pvr_out_if import pvr_pkg::*; ();
  logic valid;
  logic ready;
  vel_t new_vel_x;
  vel_t new_vel_y;
  vel_t new_vel_z;
  vel_t speed_out;
  logic was_moving;

  modport source (output valid, new_vel_x, new_vel_y, new_vel_z, speed_out, was_moving,
                  input ready);
  modport sink   (input valid, new_vel_x, new_vel_y, new_vel_z, speed_out, was_moving,
                  output ready);
endinterface

/* sv/pvr_front.sv */
// ----------------------------------------------------------------------------
// pvr_front: projection and rescale of the velocity vector
// Eight stages: squares and dot, sums, projection, scaled parts, new
// velocity with saturation, and the new squared length.
// ----------------------------------------------------------------------------
module pvr_front import pvr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  in_t               in_i,
  output logic              out_valid,
  output side_t             side_o,
  output logic [SQ_W-1:0]   sold_o,
  output logic [SQ_W-1:0]   snew_o
);

  function automatic vel_t sat_vel(logic [NVR_W-1:0] r);
    logic [NVR_W-VEL_W:0] hi;
    hi = r[NVR_W-1:VEL_W-1];
    if (!r[NVR_W-1] && (|hi))      return {1'b0, {(VEL_W-1){1'b1}}};
    else if (r[NVR_W-1] && !(&hi)) return {1'b1, {(VEL_W-1){1'b0}}};
    else                           return r[VEL_W-1:0];
  endfunction

  logic [8:1] vld_r;
  in_t        in_r [1:5];

  // stage 1
  logic signed [SQ_W-1:0]        sq1_nxt [3];
  logic signed [VEL_W+NRM_W-1:0] dp1_nxt [3];
  logic        [SQ_W-1:0]        sq1_r   [3];
  logic signed [VEL_W+NRM_W-1:0] dp1_r   [3];
  // stage 2
  logic signed [DOT_W-1:0] dsum;
  logic        [DOT_W-1:0] drnd;
  logic        [SQ_W-1:0]  sold_r [2:8];
  logic                    mv_r   [2:8];
  logic signed [D16_W-1:0] d16_r;
  // stage 3
  logic signed [P_W-1:0]   p3_nxt [3];
  logic signed [P_W-1:0]   p3_r   [3];
  // stage 4
  logic signed [PARA_W-1:0] vs4    [3];
  logic signed [PA_W-1:0]   pa4_nxt [3];
  logic signed [PARA_W-1:0] para4_nxt [3];
  logic signed [PA_W-1:0]   pa4_r  [3];
  logic signed [PARA_W-1:0] para4_r [3];
  // stage 5
  logic signed [PB_W-1:0]   pb5_nxt [3];
  logic signed [PB_W-1:0]   pb5_r  [3];
  logic signed [PA_W-1:0]   pa5_r  [3];
  // stage 6
  logic signed [ACC_W-1:0]  acc6   [3];
  logic        [ACC_W-1:0]  arnd6  [3];
  vel_t                     nv6_nxt [3];
  vel_t                     nv_r   [6:8][3];
  vel_t                     sp_r   [6:8];
  // stage 7
  logic signed [SQ_W-1:0]   sq7_nxt [3];
  logic        [SQ_W-1:0]   sq7_r  [3];
  logic        [SQ_W-1:0]   snew_nxt;
  logic        [SQ_W-1:0]   snew_r;
  logic                     stop_r;

  always_comb begin
    vel_t v0 [3];
    nrm_t n0 [3];
    v0[0] = in_i.vel_x;    v0[1] = in_i.vel_y;    v0[2] = in_i.vel_z;
    n0[0] = in_i.normal_x; n0[1] = in_i.normal_y; n0[2] = in_i.normal_z;
    for (int i = 0; i < 3; i++) begin
      sq1_nxt[i] = v0[i] * v0[i];
      dp1_nxt[i] = n0[i] * v0[i];
    end
  end

  always_comb begin
    dsum = dp1_r[0] + dp1_r[1] + dp1_r[2];
    drnd = dsum + (DOT_W'(1) << (FRAC_N - 1));
  end

  always_comb begin
    nrm_t n2 [3];
    n2[0] = in_r[2].normal_x; n2[1] = in_r[2].normal_y; n2[2] = in_r[2].normal_z;
    for (int i = 0; i < 3; i++) begin
      p3_nxt[i] = n2[i] * d16_r;
    end
  end

  always_comb begin
    vel_t v3 [3];
    nrm_t ps3;
    v3[0] = in_r[3].vel_x; v3[1] = in_r[3].vel_y; v3[2] = in_r[3].vel_z;
    ps3 = in_r[3].perp_scale;
    for (int i = 0; i < 3; i++) begin
      vs4[i]       = {{(PARA_W-VEL_W-FRAC_N){v3[i][VEL_W-1]}}, v3[i], FRAC_N'(0)};
      para4_nxt[i] = vs4[i] - p3_r[i];
      pa4_nxt[i]   = p3_r[i] * ps3;
    end
  end

  always_comb begin
    nrm_t pa4s;
    pa4s = in_r[4].para_scale;
    for (int i = 0; i < 3; i++) begin
      pb5_nxt[i] = para4_r[i] * pa4s;
    end
  end

  // Round half up, drop 28 fraction bits, saturate; pass through when not moving.
  always_comb begin
    vel_t v5 [3];
    v5[0] = in_r[5].vel_x; v5[1] = in_r[5].vel_y; v5[2] = in_r[5].vel_z;
    for (int i = 0; i < 3; i++) begin
      acc6[i]    = pa5_r[i] + pb5_r[i];
      arnd6[i]   = acc6[i] + (ACC_W'(1) << (ACC_SH - 1));
      nv6_nxt[i] = mv_r[5] ? sat_vel(arnd6[i][ACC_W-1:ACC_SH]) : v5[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq7_nxt[i] = nv_r[6][i] * nv_r[6][i];
    end
    snew_nxt = sq7_r[0] + sq7_r[1] + sq7_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[7:1], in_valid};
    end
    if (en) begin
      in_r[1] <= in_i;
      for (int k = 2; k <= 5; k++) in_r[k] <= in_r[k-1];
      for (int i = 0; i < 3; i++) begin
        sq1_r[i]   <= sq1_nxt[i];
        dp1_r[i]   <= dp1_nxt[i];
        p3_r[i]    <= p3_nxt[i];
        pa4_r[i]   <= pa4_nxt[i];
        para4_r[i] <= para4_nxt[i];
        pb5_r[i]   <= pb5_nxt[i];
        pa5_r[i]   <= pa4_r[i];
        nv_r[6][i] <= nv6_nxt[i];
        nv_r[7][i] <= nv_r[6][i];
        nv_r[8][i] <= nv_r[7][i];
        sq7_r[i]   <= sq7_nxt[i];
      end
      sold_r[2] <= sq1_r[0] + sq1_r[1] + sq1_r[2];
      mv_r[2]   <= (sq1_r[0] + sq1_r[1] + sq1_r[2]) >= THRESH_SQ;
      for (int k = 3; k <= 8; k++) begin
        sold_r[k] <= sold_r[k-1];
        mv_r[k]   <= mv_r[k-1];
      end
      d16_r   <= drnd[DOT_W-1:FRAC_N];
      sp_r[6] <= in_r[5].speed_in;
      sp_r[7] <= sp_r[6];
      sp_r[8] <= sp_r[7];
      snew_r  <= snew_nxt;
      stop_r  <= snew_nxt < THRESH_SQ;
    end
  end

  assign out_valid      = vld_r[8];
  assign side_o.vx      = nv_r[8][0];
  assign side_o.vy      = nv_r[8][1];
  assign side_o.vz      = nv_r[8][2];
  assign side_o.spd     = sp_r[8];
  assign side_o.moving  = mv_r[8];
  assign side_o.stopped = stop_r;
  assign sold_o         = sold_r[8];
  assign snew_o         = snew_r;

endmodule

/* sv/pvr_root.sv */
// ----------------------------------------------------------------------------
// pvr_root: two-lane pipelined square root
// One root digit per stage for the old and the new squared length.
// ----------------------------------------------------------------------------
module pvr_root import pvr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  side_t             side_i,
  input  logic [SQ_W-1:0]   sold_i,
  input  logic [SQ_W-1:0]   snew_i,
  output logic              out_valid,
  output side_t             side_o,
  output logic [ROOT_W-1:0] lold_o,
  output logic [ROOT_W-1:0] lnew_o
);

  logic              vld_r [1:ROOT_W];
  sqrt_st_t          ro_r  [1:ROOT_W];
  sqrt_st_t          rn_r  [1:ROOT_W];
  logic [SQ_W-1:0]   so_r  [1:ROOT_W];
  logic [SQ_W-1:0]   sn_r  [1:ROOT_W];
  side_t             sd_r  [1:ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    localparam int PI = ROOT_W - 1 - k;
    sqrt_st_t        ro_i, rn_i;
    logic [SQ_W-1:0] so_i, sn_i;
    side_t           sd_i;
    logic            v_i;
    logic [1:0]      po, pn;

    if (k == 0) begin : g_src
      assign ro_i = '0;
      assign rn_i = '0;
      assign so_i = sold_i;
      assign sn_i = snew_i;
      assign sd_i = side_i;
      assign v_i  = in_valid;
    end else begin : g_prev
      assign ro_i = ro_r[k];
      assign rn_i = rn_r[k];
      assign so_i = so_r[k];
      assign sn_i = sn_r[k];
      assign sd_i = sd_r[k];
      assign v_i  = vld_r[k];
    end

    // low radicand bits are the zeros of the << 30
    if (2 * PI >= RAD_SH) begin : g_pair
      assign po = so_i[2*PI-RAD_SH +: 2];
      assign pn = sn_i[2*PI-RAD_SH +: 2];
    end else begin : g_zero
      assign po = 2'b00;
      assign pn = 2'b00;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= v_i;
      end
      if (en) begin
        ro_r[k+1] <= sqrt_step(ro_i, po);
        rn_r[k+1] <= sqrt_step(rn_i, pn);
        so_r[k+1] <= so_i;
        sn_r[k+1] <= sn_i;
        sd_r[k+1] <= sd_i;
      end
    end
  end

  assign out_valid = vld_r[ROOT_W];
  assign side_o    = sd_r[ROOT_W];
  assign lold_o    = ro_r[ROOT_W].root;
  assign lnew_o    = rn_r[ROOT_W].root;

endmodule

/* sv/pvr_ratio.sv */
// ----------------------------------------------------------------------------
// pvr_ratio: speed times length ratio
// Split multiply, rounding add, overflow check, one quotient bit per
// stage, then saturation and the special-case select.
// ----------------------------------------------------------------------------
module pvr_ratio import pvr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  side_t             side_i,
  input  logic [ROOT_W-1:0] lold_i,
  input  logic [ROOT_W-1:0] lnew_i,
  output logic              out_valid,
  output res_t              res_o
);

  logic [VEL_W-1:0] mag0;

  // stage 1: partial products
  logic                    v1_r;
  logic [VEL_W+LO_W-1:0]   plo_r;
  logic [VEL_W+HI_W-1:0]   phi_r;
  logic [ROOT_W-1:0]       l1_r;
  side_t                   s1_r;
  // stage 2: numerator
  logic                    v2_r;
  logic [NUM_W-1:0]        num2_r;
  logic [ROOT_W-1:0]       l2_r;
  side_t                   s2_r;
  // stage 3: overflow and start
  logic                    v3_r;
  logic                    ov3_r;
  logic [ROOT_W:0]         rem3_r;
  logic [QUO_W-1:0]        lo3_r;
  logic [ROOT_W-1:0]       l3_r;
  side_t                   s3_r;
  // divider stages
  logic                    vd_r  [1:QUO_W];
  logic [ROOT_W:0]         dr_r  [1:QUO_W];
  logic [QUO_W-1:0]        dq_r  [1:QUO_W];
  logic [QUO_W-1:0]        dn_r  [1:QUO_W];
  logic [ROOT_W-1:0]       dl_r  [1:QUO_W];
  logic                    dov_r [1:QUO_W];
  side_t                   ds_r  [1:QUO_W];
  // final
  logic                    vf_r;
  res_t                    res_r;
  res_t                    res_nxt;

  assign mag0 = side_i.spd[VEL_W-1] ? (VEL_W'(0) - side_i.spd) : side_i.spd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    if (en) begin
      plo_r  <= mag0 * lnew_i[LO_W-1:0];
      phi_r  <= mag0 * lnew_i[ROOT_W-1:LO_W];
      l1_r   <= lold_i;
      s1_r   <= side_i;
      num2_r <= NUM_W'(plo_r) + (NUM_W'(phi_r) << LO_W) + NUM_W'(l1_r >> 1);
      l2_r   <= l1_r;
      s2_r   <= s1_r;
      ov3_r  <= num2_r[NUM_W-1:QUO_W] >= l2_r;
      rem3_r <= {1'b0, num2_r[NUM_W-1:QUO_W]};
      lo3_r  <= num2_r[QUO_W-1:0];
      l3_r   <= l2_r;
      s3_r   <= s2_r;
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    logic              v_i, ov_i;
    logic [ROOT_W:0]   r_i, r2, rs;
    logic [QUO_W-1:0]  q_i, n_i;
    logic [ROOT_W-1:0] l_i;
    side_t             s_i;
    logic              ge;

    if (j == 0) begin : g_src
      assign v_i  = v3_r;
      assign ov_i = ov3_r;
      assign r_i  = rem3_r;
      assign q_i  = '0;
      assign n_i  = lo3_r;
      assign l_i  = l3_r;
      assign s_i  = s3_r;
    end else begin : g_prev
      assign v_i  = vd_r[j];
      assign ov_i = dov_r[j];
      assign r_i  = dr_r[j];
      assign q_i  = dq_r[j];
      assign n_i  = dn_r[j];
      assign l_i  = dl_r[j];
      assign s_i  = ds_r[j];
    end

    assign r2 = {r_i[ROOT_W-1:0], n_i[QUO_W-1-j]};
    assign ge = r2 >= {1'b0, l_i};
    assign rs = ge ? (r2 - {1'b0, l_i}) : r2;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[j+1] <= 1'b0;
      end else if (en) begin
        vd_r[j+1] <= v_i;
      end
      if (en) begin
        dr_r[j+1]  <= rs;
        dq_r[j+1]  <= {q_i[QUO_W-2:0], ge};
        dn_r[j+1]  <= n_i;
        dl_r[j+1]  <= l_i;
        dov_r[j+1] <= ov_i;
        ds_r[j+1]  <= s_i;
      end
    end
  end

  always_comb begin
    side_t            sd;
    logic             neg;
    logic [VEL_W-1:0] lim;
    logic [VEL_W-1:0] m;
    logic [VEL_W-1:0] so;
    sd  = ds_r[QUO_W];
    neg = sd.spd[VEL_W-1];
    lim = neg ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
    m   = (dov_r[QUO_W] || (dq_r[QUO_W] > lim)) ? lim : dq_r[QUO_W];
    so  = neg ? (VEL_W'(0) - m) : m;
    res_nxt.new_vel_x  = sd.vx;
    res_nxt.new_vel_y  = sd.vy;
    res_nxt.new_vel_z  = sd.vz;
    res_nxt.was_moving = sd.moving;
    priority if (!sd.moving) res_nxt.speed_out = sd.spd;
    else if (sd.stopped)     res_nxt.speed_out = '0;
    else                     res_nxt.speed_out = so;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= vd_r[QUO_W];
    end
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = vf_r;
  assign res_o     = res_r;

endmodule

/* sv/plane_velocity_rescale.sv */
// ----------------------------------------------------------------------------
// plane_velocity_rescale: velocity rescale against a collision plane
// Projection, length roots and speed ratio in one streaming pipeline.
// ----------------------------------------------------------------------------
// The block takes one request per clock and returns one result per request,
// in order. From acceptance to out_ch.valid a request passes 8 stages of
// projection and rescale, 47 stages of square root (one root digit per
// stage, old and new length side by side), 36 stages of speed ratio (split
// multiply, rounding add, overflow check, 32 quotient stages, saturation),
// and the output buffer. Throughput is one request per cycle for as long as
// the consumer keeps taking results; a two-entry output buffer absorbs a
// stalled result, and the whole pipeline holds in place while the buffer is
// full. Velocities and speed are Q16.16, normal and scales Q2.14; results
// saturate, a slow input passes through with was_moving low, and a result
// whose new length falls below the threshold reports zero speed.
// ----------------------------------------------------------------------------
module plane_velocity_rescale import pvr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  pvr_in_if.sink       in_ch,
  pvr_out_if.source    out_ch
);

  logic              en;
  in_t               req;

  logic              fr_valid;
  side_t             fr_side;
  logic [SQ_W-1:0]   fr_sold;
  logic [SQ_W-1:0]   fr_snew;

  logic              rt_valid;
  side_t             rt_side;
  logic [ROOT_W-1:0] rt_lold;
  logic [ROOT_W-1:0] rt_lnew;

  logic              ra_valid;
  res_t              ra_res;

  res_t              buf_r [2];
  logic              wp_r;
  logic              rp_r;
  logic [1:0]        cnt_r;
  logic [1:0]        cnt_nxt;
  logic              push;
  logic              pop;
  res_t              head;

  // Advance every stage together unless the output buffer is full.
  assign en          = (cnt_r != 2'd2);
  assign in_ch.ready = en;

  assign req.normal_x   = in_ch.normal_x;
  assign req.normal_y   = in_ch.normal_y;
  assign req.normal_z   = in_ch.normal_z;
  assign req.perp_scale = in_ch.perp_scale;
  assign req.para_scale = in_ch.para_scale;
  assign req.vel_x      = in_ch.vel_x;
  assign req.vel_y      = in_ch.vel_y;
  assign req.vel_z      = in_ch.vel_z;
  assign req.speed_in   = in_ch.speed_in;

  pvr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_i      (req),
    .out_valid (fr_valid),
    .side_o    (fr_side),
    .sold_o    (fr_sold),
    .snew_o    (fr_snew)
  );

  pvr_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .side_i    (fr_side),
    .sold_i    (fr_sold),
    .snew_i    (fr_snew),
    .out_valid (rt_valid),
    .side_o    (rt_side),
    .lold_o    (rt_lold),
    .lnew_o    (rt_lnew)
  );

  pvr_ratio u_ratio (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rt_valid),
    .side_i    (rt_side),
    .lold_i    (rt_lold),
    .lnew_i    (rt_lnew),
    .out_valid (ra_valid),
    .res_o     (ra_res)
  );

  // Output buffer: push a finished result, pop on the result handshake.
  assign push = en && ra_valid;
  assign pop  = out_ch.valid && out_ch.ready;

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      buf_r[wp_r] <= ra_res;
    end
  end

  assign head              = buf_r[rp_r];
  assign out_ch.valid      = (cnt_r != 2'd0);
  assign out_ch.new_vel_x  = head.new_vel_x;
  assign out_ch.new_vel_y  = head.new_vel_y;
  assign out_ch.new_vel_z  = head.new_vel_z;
  assign out_ch.speed_out  = head.speed_out;
  assign out_ch.was_moving = head.was_moving;

`ifndef NO_ASSERTIONS
  a_cnt_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && push) |=> out_ch.valid)
    else $error("pushed result not presented");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("buffer count did not drop on pop");
`endif

endmodule
